// ===== hdl/tccs_pkg.sv =====
// Package for the text console cursor/scroll unit.
// Beat structs, screen cell layout, character codes and default geometry.
// No dependencies.
package tccs_pkg;

	localparam int ROW_WIDTH_DEF = 80;
	localparam int ROW_COUNT_DEF = 25;

	localparam int CURSOR_W = 11;
	localparam int ADDR_W   = 11;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] SPACE_CODE   = 8'd32;
	localparam logic [7:0] ATTR_RESET   = 8'd7;

	localparam logic KIND_PUT  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic [7:0] attr;
		logic [7:0] chr;
	} cell_t;

	typedef struct packed {
		logic              kind;
		logic [7:0]        char_code;
		logic [ADDR_W-1:0] read_address;
	} in_beat_t;

	typedef struct packed {
		logic [CURSOR_W-1:0] cursor_position;
		logic [7:0]          read_char;
		logic [7:0]          read_attribute;
		logic                scrolled;
	} out_beat_t;

endpackage

// ===== hdl/tccs_screen_ram.sv =====
// Screen cell store: one write port, one read port with registered data.
// Depends on tccs_pkg for the cell type.
module tccs_screen_ram
	import tccs_pkg::*;
#(
	parameter int DEPTH = ROW_WIDTH_DEF * ROW_COUNT_DEF,
	parameter int AW    = $clog2(ROW_WIDTH_DEF * ROW_COUNT_DEF)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  cell_t         wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output cell_t         rd_data
);

	cell_t mem [DEPTH];
	cell_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/text_console_cursor_scroll_unit.sv =====
// Text console writer: cursor tracking, screen store, scroll sequencer.
// Depends on tccs_pkg and tccs_screen_ram.
// Usage
//   in channel  (in_valid / in_stall / in_data): one beat per put or read.
//     kind = put : char_code written at the cursor (newline moves to next row).
//     kind = read: returns the cell at read_address (zero beyond the screen).
//   out channel (out_valid / out_stall / out_data): one beat per input beat,
//     in order, with the cursor after the step and a scroll flag.
//   cfg_we / cfg_wdata: attribute byte for written and blanked cells.
// Timing
//   Put without scroll: result registered on acceptance.
//   Read: synchronous memory read first, then the result is registered.
//   Put that scrolls: one priming read, then one cell moved per cycle through
//     the single read and write port pair; input stalls.
//   One beat is in flight at a time; a new beat is taken while the output
//   register drains.
// Reset
//   After arst_n all CELL_COUNT cells of the store are cleared, one cell per cycle,
//   with in_stall high; cursor goes to zero, attribute to 7.
// Back-pressure: while out_stall holds a result, out_data stays put, in_stall high.
module text_console_cursor_scroll_unit
	import tccs_pkg::*;
#(
	parameter int ROW_WIDTH = ROW_WIDTH_DEF,
	parameter int ROW_COUNT = ROW_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data,
	input  logic      cfg_we,
	input  logic [7:0] cfg_wdata
);

	localparam int CELL_COUNT = ROW_WIDTH * ROW_COUNT;
	localparam int AW = $clog2(CELL_COUNT);
	localparam int CB = $clog2(ROW_WIDTH);
	localparam int RB = $clog2(ROW_COUNT);

	localparam logic [2:0] S_CLEAR     = 3'd0;
	localparam logic [2:0] S_RUN       = 3'd1;
	localparam logic [2:0] S_READ      = 3'd2;
	localparam logic [2:0] S_SCR_PRIME = 3'd3;
	localparam logic [2:0] S_SCROLL    = 3'd4;

	logic [2:0]    state_q;
	logic [AW-1:0] cursor_q;
	logic [CB-1:0] col_q;
	logic [RB-1:0] row_q;
	logic [AW-1:0] wp_q;
	logic [7:0]    attr_q;
	logic          rd_oob_q;
	logic          out_valid_q;
	out_beat_t     out_q;

	logic          accept;
	logic          is_put;
	logic          is_nl;
	logic          wrap;
	logic          do_scroll;
	logic          addr_ok;
	logic          out_free;
	logic          out_load;
	logic          scr_last;
	logic [AW:0]   nxt_rd;
	cell_t         blank;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	cell_t         wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	cell_t         rd_data;

	assign out_free  = !(out_valid_q && out_stall);
	assign in_stall  = !((state_q == S_RUN) && out_free);
	assign accept    = in_valid && !in_stall;
	assign is_put    = (in_data.kind == KIND_PUT);
	assign is_nl     = (in_data.char_code == NEWLINE_CODE);
	assign wrap      = is_nl || (col_q == CB'(ROW_WIDTH - 1));
	assign do_scroll = is_put && wrap && (row_q == RB'(ROW_COUNT - 1));
	assign addr_ok   = (32'(in_data.read_address) < CELL_COUNT);
	assign scr_last  = (wp_q == AW'(CELL_COUNT - 1));
	assign nxt_rd    = {1'b0, wp_q} + (AW + 1)'(ROW_WIDTH + 1);
	assign blank     = '{attr: attr_q, chr: SPACE_CODE};
	assign out_load  = ((state_q == S_RUN) && accept && is_put && !do_scroll)
		|| (state_q == S_READ) || ((state_q == S_SCROLL) && scr_last);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wp_q;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = AW'(in_data.read_address);
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_RUN: begin
				wr_en   = accept && is_put && !is_nl;
				wr_addr = cursor_q;
				wr_data = '{attr: attr_q, chr: in_data.char_code};
				rd_en   = accept && !is_put && addr_ok;
			end
			S_SCR_PRIME: begin
				rd_en   = 1'b1;
				rd_addr = AW'(ROW_WIDTH);
			end
			S_SCROLL: begin
				wr_en   = 1'b1;
				wr_data = (32'(wp_q) < CELL_COUNT - ROW_WIDTH) ? rd_data : blank;
				rd_en   = (32'(nxt_rd) < CELL_COUNT);
				rd_addr = nxt_rd[AW-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	tccs_screen_ram #(
		.DEPTH(CELL_COUNT),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_we) begin
			attr_q <= cfg_wdata;
		end
	end

	// control: sequencer, cursor, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cursor_q    <= '0;
			col_q       <= '0;
			row_q       <= '0;
			wp_q        <= '0;
			rd_oob_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (scr_last) begin
						wp_q    <= '0;
						state_q <= S_RUN;
					end else begin
						wp_q <= wp_q + AW'(1);
					end
				end
				S_RUN: begin
					if (accept) begin
						if (!is_put) begin
							rd_oob_q <= !addr_ok;
							state_q  <= S_READ;
						end else if (do_scroll) begin
							cursor_q <= AW'(CELL_COUNT - ROW_WIDTH);
							row_q    <= RB'(ROW_COUNT - 1);
							col_q    <= '0;
							wp_q     <= '0;
							state_q  <= S_SCR_PRIME;
						end else begin
							if (wrap) begin
								row_q <= row_q + RB'(1);
								col_q <= '0;
							end else begin
								col_q <= col_q + CB'(1);
							end
							if (is_nl) begin
								cursor_q <= cursor_q - AW'(col_q) + AW'(ROW_WIDTH);
							end else begin
								cursor_q <= cursor_q + AW'(1);
							end
							out_valid_q <= 1'b1;
						end
					end
				end
				S_READ: begin
					out_valid_q <= 1'b1;
					state_q     <= S_RUN;
				end
				S_SCR_PRIME: begin
					state_q <= S_SCROLL;
				end
				S_SCROLL: begin
					wp_q <= wp_q + AW'(1);
					if (scr_last) begin
						out_valid_q <= 1'b1;
						state_q     <= S_RUN;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_RUN: begin
				if (accept && is_put && !do_scroll) begin
					out_q.cursor_position <= is_nl
						? CURSOR_W'(cursor_q - AW'(col_q) + AW'(ROW_WIDTH))
						: CURSOR_W'(cursor_q + AW'(1));
					out_q.read_char       <= '0;
					out_q.read_attribute  <= '0;
					out_q.scrolled        <= 1'b0;
				end
			end
			S_READ: begin
				out_q.cursor_position <= CURSOR_W'(cursor_q);
				out_q.read_char       <= rd_oob_q ? 8'd0 : rd_data.chr;
				out_q.read_attribute  <= rd_oob_q ? 8'd0 : rd_data.attr;
				out_q.scrolled        <= 1'b0;
			end
			S_SCROLL: begin
				if (scr_last) begin
					out_q.cursor_position <= CURSOR_W'(cursor_q);
					out_q.read_char       <= '0;
					out_q.read_attribute  <= '0;
					out_q.scrolled        <= 1'b1;
				end
			end
			default: begin
				out_q <= out_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	a_cursor_rowcol: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cursor_q) == 32'(row_q) * ROW_WIDTH + 32'(col_q))
		else $error("cursor out of step with row and column");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.scrolled) |->
		out_q.cursor_position == CURSOR_W'(CELL_COUNT - ROW_WIDTH))
		else $error("scroll result not at start of last row");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (32'(wr_addr) < CELL_COUNT))
		else $error("screen write beyond last cell");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ || state_q == S_SCROLL) |-> !out_valid_q)
		else $error("result register busy during read or scroll");
`endif

endmodule
